### rtl/core/lkv_pkg.sv
// ----------------------------------------------------------------------------
// lkv_pkg
// Shared types and constants for the LRU key/value cache.
// ----------------------------------------------------------------------------
package lkv_pkg;

    // Field widths
    localparam int KEY_W      = 32;
    localparam int VAL_W      = 32;
    localparam int CAP_W      = 5;

    // Default number of cells and capacity after reset
    localparam int          DEPTH_DEF = 16;
    localparam logic [4:0]  CAP_RESET = 5'd16;

    // Stream payload widths (padded to whole bytes)
    localparam int S_TDATA_W = 64;
    localparam int M_TDATA_W = 72;

    // Request kinds carried on s_tuser
    localparam logic ACT_GET = 1'b0;
    localparam logic ACT_PUT = 1'b1;

    // Sequencer states
    typedef enum logic {
        ST_IDLE,
        ST_UPDATE
    } lkv_state_t;

    // Per-cell control from the sequencer
    typedef struct packed {
        logic cmp_en;   // latch the compare result for the incoming key
        logic load;     // take the entry offered on the cell's input
    } lkv_cell_ctl_t;

endpackage

### rtl/core/lkv_cell.sv
// ----------------------------------------------------------------------------
// lkv_cell
// One entry of the recency chain: holds a key and a value, compares the
// broadcast key and shifts in its neighbor's entry when told to.
// ----------------------------------------------------------------------------
module lkv_cell
    import lkv_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  lkv_cell_ctl_t       ctl,
    input  logic                live,       // cell holds a valid entry
    input  logic [KEY_W-1:0]    cmp_key,
    input  logic [KEY_W-1:0]    in_key,
    input  logic [VAL_W-1:0]    in_value,
    output logic [KEY_W-1:0]    key,
    output logic [VAL_W-1:0]    value,
    output logic                match
);

    logic [KEY_W-1:0] key_reg;
    logic [VAL_W-1:0] value_reg;
    logic             match_reg;
    logic             match_next;

    // Associative compare against the broadcast key
    always_comb begin
        match_next = match_reg;
        if (ctl.cmp_en) begin
            match_next = live && (key_reg == cmp_key);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            match_reg <= 1'b0;
        end else begin
            match_reg <= match_next;
        end
    end

    // Entry storage, shifted from the neighbor
    always_ff @(posedge aclk) begin
        if (ctl.load) begin
            key_reg   <= in_key;
            value_reg <= in_value;
        end
    end

    assign key   = key_reg;
    assign value = value_reg;
    assign match = match_reg;

endmodule

### rtl/core/lru_key_value_cache.sv
// Flow: a request's compare result is latched when its beat is accepted; the chain
// update then registers the result beat. The update waits while the output register holds
// an untaken beat, and no new request is taken until the update is done.
// Reset: synchronous, active low; store empty, capacity 16.
// A capacity write empties the store in the same cycle; it wins over a request.
// ----------------------------------------------------------------------------
// lru_key_value_cache
// Fully associative key/value cache with LRU replacement, built as a chain of
// cells ordered by recency: cell 0 is most recent, cell occupancy-1 is least.
// ----------------------------------------------------------------------------
module lru_key_value_cache
    import lkv_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
)
(
    input  logic                    aclk,
    input  logic                    aresetn,
    // request stream
    input  logic                    s_tvalid,
    output logic                    s_tready,
    input  logic [S_TDATA_W-1:0]    s_tdata,    // key[31:0], value[63:32]
    input  logic                    s_tuser,    // action[0]
    // result stream
    output logic                    m_tvalid,
    input  logic                    m_tready,
    output logic [M_TDATA_W-1:0]    m_tdata,    // hit[0], read_value[32:1],
                                                // evicted[33], evicted_key[65:34], zero pad
    // capacity write
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [CAP_W-1:0]        cfg_data
);

    localparam int IDXW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNTW = $clog2(DEPTH + 1);
    localparam int CMPW = (CNTW > CAP_W) ? CNTW : CAP_W;

    // ------------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------------
    lkv_state_t             state_reg, state_next;
    logic [CAP_W-1:0]       cap_reg, cap_next;
    logic [CNTW-1:0]        occ_reg, occ_next;
    logic                   act_reg;
    logic [KEY_W-1:0]       key_reg;
    logic [VAL_W-1:0]       value_reg;
    logic                   m_valid_reg, m_valid_next;
    logic [M_TDATA_W-1:0]   m_data_reg, m_data_next;

    // Chain signals
    lkv_cell_ctl_t          cell_ctl   [DEPTH];
    logic [KEY_W-1:0]       cell_key   [DEPTH];
    logic [VAL_W-1:0]       cell_value [DEPTH];
    logic [KEY_W-1:0]       cell_in_key   [DEPTH];
    logic [VAL_W-1:0]       cell_in_value [DEPTH];
    logic [DEPTH-1:0]       match_vec;
    logic [DEPTH-1:0]       live_vec;

    // Decode
    logic                   s_fire, cfg_fire, out_free, upd_fire;
    logic                   hit, is_put, full, evict, do_shift;
    logic [IDXW-1:0]        hit_idx, lru_idx;
    logic [VAL_W-1:0]       hit_value;
    logic [CNTW-1:0]        eff_cap, last_pos, occ_m1;
    logic [CMPW-1:0]        cap_ext;
    logic [VAL_W-1:0]       read_value;
    logic [KEY_W-1:0]       evicted_key;

    assign s_fire   = s_tvalid && s_tready;
    assign cfg_fire = cfg_valid && cfg_ready;
    assign out_free = !m_valid_reg || m_tready;
    assign upd_fire = (state_reg == ST_UPDATE) && out_free;

    // ------------------------------------------------------------------------
    // Effective capacity: zero reads as one, saturates at DEPTH
    // ------------------------------------------------------------------------
    always_comb begin
        cap_ext = CMPW'(cap_reg);
        if (cap_reg == '0) begin
            eff_cap = CNTW'(1);
        end else if (cap_ext > CMPW'(DEPTH)) begin
            eff_cap = CNTW'(DEPTH);
        end else begin
            eff_cap = CNTW'(cap_ext);
        end
    end

    // ------------------------------------------------------------------------
    // Hit decode over the registered match bits
    // ------------------------------------------------------------------------
    always_comb begin
        hit_idx   = '0;
        hit_value = '0;
        for (int i = 0; i < DEPTH; i++) begin
            if (match_vec[i]) begin
                hit_idx   = hit_idx | IDXW'(i);
                hit_value = hit_value | cell_value[i];
            end
        end
    end

    assign hit      = |match_vec;
    assign is_put   = (act_reg == ACT_PUT);
    assign full     = (occ_reg >= eff_cap);
    assign evict    = is_put && !hit && full;
    assign do_shift = hit || is_put;
    assign occ_m1   = occ_reg - CNTW'(1);
    assign lru_idx  = occ_m1[IDXW-1:0];

    // Deepest cell that moves: the hit cell, or on an insert the tail when full, else the first free cell
    always_comb begin
        if (hit) begin
            last_pos = CNTW'(hit_idx);
        end else if (full) begin
            last_pos = occ_m1;
        end else begin
            last_pos = occ_reg;
        end
    end

    // ------------------------------------------------------------------------
    // Cell chain
    // ------------------------------------------------------------------------
    genvar g;
    generate
        for (g = 0; g < DEPTH; g++) begin : g_cell
            assign live_vec[g]         = (CNTW'(g) < occ_reg);
            assign cell_ctl[g].cmp_en  = s_fire;
            assign cell_ctl[g].load    = upd_fire && do_shift && (CNTW'(g) <= last_pos);

            if (g == 0) begin : g_head
                // Front entry: the request key, new value on a put
                assign cell_in_key[g]   = key_reg;
                assign cell_in_value[g] = is_put ? value_reg : hit_value;
            end else begin : g_body
                assign cell_in_key[g]   = cell_key[g-1];
                assign cell_in_value[g] = cell_value[g-1];
            end

            lkv_cell u_cell (
                .aclk     (aclk),
                .aresetn  (aresetn),
                .ctl      (cell_ctl[g]),
                .live     (live_vec[g]),
                .cmp_key  (s_tdata[KEY_W-1:0]),
                .in_key   (cell_in_key[g]),
                .in_value (cell_in_value[g]),
                .key      (cell_key[g]),
                .value    (cell_value[g]),
                .match    (match_vec[g])
            );
        end
    endgenerate

    // ------------------------------------------------------------------------
    // Sequencer: next state
    // ------------------------------------------------------------------------
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Sequencer: handshake outputs; a pending capacity write holds off requests
    always_comb begin
        s_tready  = 1'b0;
        cfg_ready = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready  = !cfg_valid;
                cfg_ready = 1'b1;
            end
            ST_UPDATE: begin
                s_tready  = 1'b0;
                cfg_ready = 1'b0;
            end
            default: begin
                s_tready  = 1'b0;
                cfg_ready = 1'b0;
            end
        endcase
    end

    // ------------------------------------------------------------------------
    // Occupancy and capacity
    // ------------------------------------------------------------------------
    always_comb begin
        cap_next = cap_reg;
        occ_next = occ_reg;
        if (cfg_fire) begin
            cap_next = cfg_data;
            occ_next = '0;
        end else if (upd_fire && is_put && !hit && !full) begin
            occ_next = occ_reg + CNTW'(1);
        end
    end

    // ------------------------------------------------------------------------
    // Result beat
    // ------------------------------------------------------------------------
    always_comb begin
        if (is_put) begin
            read_value = '0;
        end else if (hit) begin
            read_value = hit_value;
        end else begin
            read_value = '1;
        end
        evicted_key = evict ? cell_key[lru_idx] : '0;
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (upd_fire) begin
            m_valid_next = 1'b1;
            m_data_next  = {6'd0, evicted_key, evict, read_value, hit};
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    // ------------------------------------------------------------------------
    // Control registers
    // ------------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cap_reg     <= CAP_RESET;
            occ_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cap_reg     <= cap_next;
            occ_reg     <= occ_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            act_reg   <= s_tuser;
            key_reg   <= s_tdata[KEY_W-1:0];
            value_reg <= s_tdata[KEY_W +: VAL_W];
        end
        m_data_reg <= m_data_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
`ifndef SYNTH
    // occupancy never exceeds the effective capacity
    a_occ_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        occ_reg <= eff_cap)
        else $error("occupancy above capacity");

    // live keys are unique, so at most one cell matches
    a_match_unique: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_UPDATE) |-> $onehot0(match_vec))
        else $error("multiple cells match one key");

    // an accepted request always moves to the update step
    a_accept_update: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire |=> (state_reg == ST_UPDATE))
        else $error("accepted request not processed");

    // an eviction replaces the tail, occupancy stays put
    a_evict_occ: assert property (@(posedge aclk) disable iff (!aresetn)
        (upd_fire && evict) |=> $stable(occ_reg))
        else $error("occupancy changed on eviction");
`endif

endmodule
